>>> design/lfsc_pkg.sv
// Shared types, constants and helpers for the line follower steering controller.
package lfsc_pkg;

   localparam int AdcBitsDefault = 12;
   localparam int SensorCount = 8;
   localparam int PosWidth = 11;
   localparam int ErrWidth = 12;
   localparam int IntWidth = 24;
   localparam int DerWidth = 13;
   localparam int CtlWidth = 24;
   localparam int DutyWidth = 16;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 16;
   localparam int NormWidth = 7;
   localparam int QueueDepth = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_KP = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_KI = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_KD = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SET_POINT = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_INT_LIMIT = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_ERR_LIMIT = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_DUTY = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_MIN_DUTY = 3'd7;

   // classified item handed from front to back
   typedef struct packed {
      logic             is_tick;
      logic             enable;
      logic             any;
      logic             has_den;
      logic signed [11:0] wsum;   // weighted sum of the pair (+-1200 range)
      logic [7:0]       den;      // pair sum, at most 200
   } work_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POS_DIV,
      ST_STEER,
      ST_TICK,
      ST_MUL,
      ST_MUL_DIV,
      ST_CTL_SUM,
      ST_DONE
   } state_type;

   // round v*100/3500 = round(v/35) for 500 < v < 3500
   function automatic logic [NormWidth-1:0] norm_mid(input logic [11:0] v);
      logic [23:0] prod;
      logic [11:0] q;
      logic [12:0] r;
      begin
         // floor(v/35) via reciprocal, then one correction step
         prod = v * 12'd1872;           // 65520/35 = 1872
         q = 12'(prod[23:16]);
         r = {1'b0, v} - 13'(q * 35);
         if (r >= 13'd35) begin
            q = q + 12'd1;
            r = r - 13'd35;
         end
         if (r >= 13'd18) q = q + 12'd1;
         norm_mid = q[NormWidth-1:0];
      end
   endfunction

endpackage

>>> design/lfsc_front.sv
// Front part: normalizes sensors, picks the neighbor pair and classifies the item.
module lfsc_front #(
   parameter int ADC_BITS = lfsc_pkg::AdcBitsDefault
) (
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_mode,
   input  logic                          req_enable,
   input  logic [8*12-1:0]               sensors,
   output logic                          q_push,
   input  logic                          q_full,
   output lfsc_pkg::work_type            q_data
);
   import lfsc_pkg::*;

   logic [NormWidth-1:0] n [SensorCount];
   logic any;
   logic signed [11:0] wsum;
   logic [7:0] den;
   logic [15:0] raw;

   always_comb begin
      any = 1'b0;
      raw = '0;
      for (int k = 0; k < SensorCount; k++) begin
         raw = 16'(sensors[k*12 +: 12]) & 16'((32'd1 << ADC_BITS) - 32'd1);
         if (raw <= 16'd500) n[k] = '0;
         else if (raw >= 16'd3500) n[k] = 7'd100;
         else n[k] = norm_mid(raw[11:0]);
         if (n[k] != '0) any = 1'b1;
      end
   end

   always_comb begin
      if (n[7] != 0 && n[0] == 0) begin
         wsum = 12'sd8 * 12'(n[7]) + 12'sd4 * 12'(n[6]);
         den = 8'(n[7]) + 8'(n[6]);
      end else if (n[0] != 0 && n[7] == 0) begin
         wsum = -(12'sd8 * 12'(n[0]) + 12'sd4 * 12'(n[1]));
         den = 8'(n[0]) + 8'(n[1]);
      end else if (n[6] != 0 && n[1] == 0) begin
         wsum = 12'sd4 * 12'(n[6]) + 12'sd2 * 12'(n[5]);
         den = 8'(n[6]) + 8'(n[5]);
      end else if (n[1] != 0 && n[6] == 0) begin
         wsum = -(12'sd4 * 12'(n[1]) + 12'sd2 * 12'(n[2]));
         den = 8'(n[1]) + 8'(n[2]);
      end else if (n[5] != 0) begin
         wsum = 12'sd2 * 12'(n[5]) + 12'(n[4]);
         den = 8'(n[5]) + 8'(n[4]);
      end else if (n[2] != 0) begin
         wsum = -(12'sd2 * 12'(n[2]) + 12'(n[3]));
         den = 8'(n[2]) + 8'(n[3]);
      end else begin
         wsum = 12'(n[4]) - 12'(n[3]);
         den = 8'(n[3]) + 8'(n[4]);
      end
   end

   assign req_full = q_full;
   assign q_push = req_push && !q_full;

   always_comb begin
      q_data.is_tick = req_mode;
      q_data.enable = req_enable;
      q_data.any = any;
      q_data.has_den = den != '0;
      q_data.wsum = wsum;
      q_data.den = den;
   end
endmodule

>>> design/lfsc_queue.sv
// Short queue between front and back parts.
module lfsc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  lfsc_pkg::work_type wdata,
   input  logic               pop,
   output logic               empty,
   output lfsc_pkg::work_type rdata
);
   import lfsc_pkg::*;

   work_type mem_ff [QueueDepth];
   logic [0:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full = cnt_ff == 2'(QueueDepth);
   assign empty = cnt_ff == 2'd0;
   assign rdata = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      cnt_in = cnt_ff;
      if (push && !full) wp_in = wp_ff + 1'b1;
      if (pop && !empty) rp_in = rp_ff + 1'b1;
      if ((push && !full) && !(pop && !empty)) cnt_in = cnt_ff + 2'd1;
      else if (!(push && !full) && (pop && !empty)) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push && !full) mem_ff[wp_ff] <= wdata;
   end
endmodule

>>> design/lfsc_back.sv
// Back part: position divide, steering, PID update and output register.
module lfsc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  lfsc_pkg::work_type    q_data,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [15:0]           rsp_right_duty,
   output logic [15:0]           rsp_left_duty,
   output logic signed [10:0]    rsp_line_position,
   output logic signed [11:0]    rsp_error_value,
   output logic [23:0]           rsp_control_value,
   output logic                  rsp_line_seen
);
   import lfsc_pkg::*;

   // configuration
   logic [15:0] kp_ff, ki_ff, kd_ff, il_ff, max_ff, min_ff;
   logic signed [10:0] sp_ff;
   logic [4:0] el_ff;

   // architectural state
   logic signed [10:0] pos_ff, pos_in;
   logic signed [11:0] err_ff, err_in, perr_ff, perr_in;
   logic signed [23:0] int_ff, int_in;
   logic signed [12:0] der_ff, der_in;
   logic [23:0] ctl_ff, ctl_in;
   logic [15:0] right_ff, right_in, left_ff, left_in;
   logic seen_ff, seen_in;

   state_type st_ff, st_in;
   work_type item_ff, item_in;
   logic rsp_valid_ff, rsp_valid_in;

   // position divider: (2*num+den) over 2*den, one quotient bit per cycle
   logic [17:0] dnum_ff, dnum_in, dq_ff, dq_in;
   logic [8:0] drem_ff, drem_in, dden_ff, dden_in;
   logic dneg_ff, dneg_in;
   logic [4:0] dcnt_ff, dcnt_in;

   // rounded divide by 100: one quotient byte per cycle
   logic [39:0] cnum_ff, cnum_in, cq_ff, cq_in;
   logic [6:0] crem_ff, crem_in;
   logic cneg_ff, cneg_in;
   logic [2:0] ccnt_ff, ccnt_in;

   // multiplier term sequencing
   logic [1:0] term_ff, term_in;
   logic signed [41:0] prod_ff, prod_in;
   logic signed [39:0] acc_ff, acc_in;

   logic [9:0] trial;
   logic [11:0] wabs;
   logic [14:0] cpart;
   logic [23:0] cmul;
   logic [7:0] cdig;
   logic [15:0] crest;
   logic [41:0] pabs;
   logic [16:0] gain;
   logic signed [24:0] opnd;
   logic signed [24:0] il_ext, inew;
   logic signed [12:0] lim;
   logic signed [16:0] tduty, floor_duty, boost;
   logic [39:0] acc_abs;
   logic signed [18:0] qsigned;
   logic signed [39:0] csigned;

   always_comb begin
      st_in = st_ff;
      item_in = item_ff;
      rsp_valid_in = rsp_valid_ff;
      pos_in = pos_ff; err_in = err_ff; perr_in = perr_ff; int_in = int_ff;
      der_in = der_ff; ctl_in = ctl_ff; right_in = right_ff; left_in = left_ff;
      seen_in = seen_ff;
      dnum_in = dnum_ff; dq_in = dq_ff; drem_in = drem_ff; dden_in = dden_ff;
      dneg_in = dneg_ff; dcnt_in = dcnt_ff;
      cnum_in = cnum_ff; cq_in = cq_ff; crem_in = crem_ff; cneg_in = cneg_ff;
      ccnt_in = ccnt_ff;
      term_in = term_ff; prod_in = prod_ff; acc_in = acc_ff;
      q_pop = 1'b0;
      trial = '0;
      gain = '0;
      opnd = '0;
      wabs = q_data.wsum[11] ? 12'(-q_data.wsum) : 12'(q_data.wsum);
      // quotient digit of (rem*256 + byte)/100 by reciprocal, then one correction
      cpart = {crem_ff, cnum_ff[39:32]};
      cmul = 24'(cpart) * 24'd655;
      cdig = cmul[23:16];
      crest = 16'(cpart) - 16'(16'(cdig) * 16'd100);
      if (crest >= 16'd100) begin
         cdig = cdig + 8'd1;
         crest = crest - 16'd100;
      end
      pabs = prod_ff[41] ? 42'(-prod_ff) : 42'(prod_ff);
      il_ext = 25'(il_ff) * 25'sd100;
      inew = '0;
      lim = 13'(el_ff) * 13'sd100;
      floor_duty = (min_ff > max_ff) ? 17'(max_ff) : 17'(min_ff);
      tduty = 17'(max_ff) - 17'(ctl_ff > 24'd65535 ? 24'd65535 : ctl_ff);
      boost = '0;
      acc_abs = acc_ff[39] ? 40'(-acc_ff) : 40'(acc_ff);
      qsigned = dneg_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
      csigned = cneg_ff ? -$signed(cq_ff) : $signed(cq_ff);
      if (rsp_valid_ff && rsp_pop) rsp_valid_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (!q_empty && !(rsp_valid_ff && !rsp_pop)) begin
               q_pop = 1'b1;
               item_in = q_data;
               rsp_valid_in = 1'b0;
               if (q_data.is_tick) begin
                  st_in = q_data.enable ? ST_TICK : ST_MUL;
                  term_in = 2'd0;
                  acc_in = '0;
               end else if (!q_data.enable) begin
                  st_in = ST_DONE;
               end else begin
                  seen_in = q_data.any;
                  if (q_data.any && q_data.has_den) begin
                     dnum_in = 18'(wabs) * 18'd200 + 18'(q_data.den);
                     dneg_in = q_data.wsum[11];
                     dden_in = {q_data.den, 1'b0};
                     dq_in = '0;
                     drem_in = '0;
                     dcnt_in = 5'd18;
                     st_in = ST_POS_DIV;
                  end else if (q_data.any) begin
                     st_in = ST_STEER;
                  end else begin
                     st_in = ST_DONE;
                  end
               end
            end
         end
         ST_POS_DIV: begin
            if (dcnt_ff != 5'd0) begin
               trial = {drem_ff, dnum_ff[17]};
               dnum_in = dnum_ff << 1;
               if (trial >= {1'b0, dden_ff}) begin
                  drem_in = 9'(trial - {1'b0, dden_ff});
                  dq_in = {dq_ff[16:0], 1'b1};
               end else begin
                  drem_in = trial[8:0];
                  dq_in = {dq_ff[16:0], 1'b0};
               end
               dcnt_in = dcnt_ff - 5'd1;
            end else begin
               pos_in = 11'(qsigned);
               st_in = ST_STEER;
            end
         end
         ST_MUL_DIV: begin
            if (ccnt_ff == 3'd6) begin
               // |p| + 50 then floor over 100 rounds halves away from zero
               cnum_in = 40'(pabs) + 40'd50;
               cneg_in = prod_ff[41];
               cq_in = '0;
               crem_in = '0;
               ccnt_in = 3'd5;
            end else if (ccnt_ff != 3'd0) begin
               cnum_in = cnum_ff << 8;
               cq_in = {cq_ff[31:0], cdig};
               crem_in = crest[6:0];
               ccnt_in = ccnt_ff - 3'd1;
            end else begin
               acc_in = acc_ff + csigned;
               term_in = term_ff + 2'd1;
               st_in = (term_ff == 2'd2) ? ST_CTL_SUM : ST_MUL;
            end
         end
         ST_STEER: begin
            if (13'(err_ff) > lim) begin
               right_in = '0; left_in = max_ff;
            end else if (13'(err_ff) < -lim) begin
               right_in = max_ff; left_in = '0;
            end else if (err_ff > 0 && 13'(err_ff) < lim) begin
               if (ctl_ff > 24'(max_ff) || tduty < 17'(min_ff)) tduty = floor_duty;
               right_in = tduty[15:0]; left_in = max_ff;
            end else if (err_ff < 0 && 13'(err_ff) > -lim) begin
               if (ctl_ff > 24'(max_ff) || tduty < 17'(min_ff)) tduty = floor_duty;
               left_in = tduty[15:0]; right_in = max_ff;
            end else begin
               boost = 17'((18'(right_ff) + 18'(left_ff)) >> 1) + 17'sd5000;
               if (boost > 17'(max_ff)) boost = 17'(max_ff);
               right_in = boost[15:0]; left_in = boost[15:0];
            end
            st_in = ST_DONE;
         end
         ST_TICK: begin
            err_in = 12'(sp_ff) + 12'(pos_ff);
            inew = 25'(int_ff);
            if (inew < il_ext && inew > -il_ext) inew = inew + 25'(err_in);
            else if (inew > il_ext) inew = il_ext;
            else if (inew < -il_ext) inew = -il_ext;
            int_in = 24'(inew);
            der_in = 13'(err_in) - 13'(perr_ff);
            perr_in = err_in;
            st_in = ST_MUL;
         end
         ST_MUL: begin
            case (term_ff)
               2'd0: begin gain = {1'b0, kp_ff}; opnd = 25'(err_ff); end
               2'd1: begin gain = {1'b0, ki_ff}; opnd = 25'(int_ff); end
               default: begin gain = {1'b0, kd_ff}; opnd = 25'(der_ff); end
            endcase
            prod_in = 42'($signed(gain) * opnd);
            ccnt_in = 3'd6;
            st_in = ST_MUL_DIV;
         end
         ST_CTL_SUM: begin
            ctl_in = (acc_abs > 40'd16777215) ? 24'hFFFFFF : acc_abs[23:0];
            st_in = ST_DONE;
         end
         ST_DONE: begin
            if (!item_ff.enable) begin
               right_in = '0; left_in = '0;
            end
            rsp_valid_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         kp_ff <= 16'd10000; ki_ff <= 16'd1; kd_ff <= 16'd1000; sp_ff <= '0;
         il_ff <= 16'd1000; el_ff <= 5'd6; max_ff <= 16'd49999; min_ff <= 16'd10000;
         pos_ff <= '0; err_ff <= '0; perr_ff <= '0; int_ff <= '0; der_ff <= '0;
         ctl_ff <= '0; right_ff <= '0; left_ff <= '0; seen_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff <= pos_in; err_ff <= err_in; perr_ff <= perr_in; int_ff <= int_in;
         der_ff <= der_in; ctl_ff <= ctl_in; right_ff <= right_in; left_ff <= left_in;
         seen_ff <= seen_in;
         if (csr_write) begin
            case (csr_index)
               CSR_KP: kp_ff <= csr_data;
               CSR_KI: ki_ff <= csr_data;
               CSR_KD: kd_ff <= csr_data;
               CSR_SET_POINT: sp_ff <= csr_data[10:0];
               CSR_INT_LIMIT: il_ff <= csr_data;
               CSR_ERR_LIMIT: el_ff <= csr_data[4:0];
               CSR_MAX_DUTY: max_ff <= csr_data;
               CSR_MIN_DUTY: min_ff <= csr_data;
               default: ;
            endcase
         end
      end
      item_ff <= item_in;
      dnum_ff <= dnum_in; dq_ff <= dq_in; drem_ff <= drem_in; dden_ff <= dden_in;
      dneg_ff <= dneg_in; dcnt_ff <= dcnt_in;
      cnum_ff <= cnum_in; cq_ff <= cq_in; crem_ff <= crem_in; cneg_ff <= cneg_in;
      ccnt_ff <= ccnt_in;
      term_ff <= term_in; prod_ff <= prod_in; acc_ff <= acc_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_right_duty = right_ff;
   assign rsp_left_duty = left_ff;
   assign rsp_line_position = pos_ff;
   assign rsp_error_value = err_ff;
   assign rsp_control_value = ctl_ff;
   assign rsp_line_seen = seen_ff;
endmodule

>>> design/line_follower_steering_controller_unit.sv
// Top level of the line follower steering controller.
// Items enter through a queue-like port: req_push with req_full; a mode 0
// item is a sensor frame of eight samples, a mode 1 item a control tick.
// Each item yields one result on the rsp_ side, read by rsp_pop while
// rsp_empty is low; results carry the held duties, position, error,
// control value and the line seen flag.
// The user must write gains, limits and duties through csr_write/csr_index/
// csr_data only while no item is in flight; the block does not enforce this.
// A front stage classifies each frame in its accept cycle and a two-entry
// queue feeds the back part, which runs one item at a time. A frame with
// a line passes the 18-step serial position divide, steering and the done
// state; an enabled tick passes the error and integral update and three
// multiplies, each rounded over 100 by a serial divide, then the control
// sum; a disabled tick skips the integral update; a frame without a divisor
// goes straight to steering and a dark or disabled frame to the done state.
// The next item is taken only when the output register is free or popped.
// A finished result waits in the output register; while it is not taken
// the back part holds, the queue fills and req_full rises.
// Reset restores the register defaults and clears the architectural state to zero.
module line_follower_steering_controller_unit #(
   parameter int ADC_BITS = lfsc_pkg::AdcBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_mode,
   input  logic               req_enable,
   input  logic [11:0]        req_sensor_0,
   input  logic [11:0]        req_sensor_1,
   input  logic [11:0]        req_sensor_2,
   input  logic [11:0]        req_sensor_3,
   input  logic [11:0]        req_sensor_4,
   input  logic [11:0]        req_sensor_5,
   input  logic [11:0]        req_sensor_6,
   input  logic [11:0]        req_sensor_7,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [15:0]        rsp_right_duty,
   output logic [15:0]        rsp_left_duty,
   output logic signed [10:0] rsp_line_position,
   output logic signed [11:0] rsp_error_value,
   output logic [23:0]        rsp_control_value,
   output logic               rsp_line_seen,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import lfsc_pkg::*;

   logic q_push, q_full, q_pop, q_empty;
   work_type q_wdata, q_rdata;

   lfsc_front #(.ADC_BITS(ADC_BITS)) u_front (
      .req_push, .req_full, .req_mode, .req_enable,
      .sensors({req_sensor_7, req_sensor_6, req_sensor_5, req_sensor_4,
                req_sensor_3, req_sensor_2, req_sensor_1, req_sensor_0}),
      .q_push, .q_full, .q_data(q_wdata)
   );

   lfsc_queue u_queue (
      .clock, .reset, .push(q_push), .full(q_full), .wdata(q_wdata),
      .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
   );

   lfsc_back u_back (
      .clock, .reset, .q_empty, .q_pop, .q_data(q_rdata),
      .csr_write, .csr_index, .csr_data,
      .rsp_empty, .rsp_pop, .rsp_right_duty, .rsp_left_duty,
      .rsp_line_position, .rsp_error_value, .rsp_control_value, .rsp_line_seen
   );
endmodule

>>> tb/tb_line_follower_steering_controller_unit.sv
// Testbench for the line follower steering controller: directed table, then random traffic.
module tb_line_follower_steering_controller_unit;
   import lfsc_pkg::*;

   typedef struct {
      logic             mode;
      logic             en;
      logic [0:7][11:0] s;
   } item_type;

   typedef struct packed {
      logic [15:0] right;
      logic [15:0] left;
      logic [10:0] pos;
      logic [11:0] err;
      logic [23:0] ctl;
      logic        seen;
   } steer_out_type;

   typedef struct {
      item_type      it;
      logic          pin;
      steer_out_type want;
   } row_type;

   localparam int WatchdogLimit = 20000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   logic             req_mode = 1'b0;
   logic             req_enable = 1'b0;
   logic [0:7][11:0] sens = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   logic [15:0]      rsp_right_duty, rsp_left_duty;
   logic signed [10:0] rsp_line_position;
   logic signed [11:0] rsp_error_value;
   logic [23:0]      rsp_control_value;
   logic             rsp_line_seen;
   logic             csr_write = 1'b0;
   logic [2:0]       csr_index = '0;
   logic [15:0]      csr_data = '0;

   line_follower_steering_controller_unit DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_mode(req_mode), .req_enable(req_enable),
      .req_sensor_0(sens[0]), .req_sensor_1(sens[1]), .req_sensor_2(sens[2]),
      .req_sensor_3(sens[3]), .req_sensor_4(sens[4]), .req_sensor_5(sens[5]),
      .req_sensor_6(sens[6]), .req_sensor_7(sens[7]),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_right_duty(rsp_right_duty), .rsp_left_duty(rsp_left_duty),
      .rsp_line_position(rsp_line_position), .rsp_error_value(rsp_error_value),
      .rsp_control_value(rsp_control_value), .rsp_line_seen(rsp_line_seen),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // controller settings and state mirrored here
   longint gain_p, gain_i, gain_d, target, int_cap, err_cap, duty_max, duty_min;
   longint pos_h, err_h, err_prev, int_sum, der_h, ctl_h, right_h, left_h;
   logic   seen_h;

   steer_out_type pending_q[$];
   int         errors = 0;
   int         send_idle = 0;
   int         recv_idle = 0;
   int         quiet_cycles = 0;

   function automatic longint round_div(longint n, longint d);
      if (n >= 0) return (2 * n + d) / (2 * d);
      return -((2 * (-n) + d) / (2 * d));
   endfunction

   function automatic longint normalize(logic [11:0] v);
      if (v <= 500) return 0;
      if (v >= 3500) return 100;
      return round_div(longint'(v) * 100, 3500);
   endfunction

   function automatic longint cap_duty(longint v);
      return (v > duty_max) ? duty_max : v;
   endfunction

   function automatic void locate_line(longint n[8]);
      longint wsum, den;
      if (n[7] > 0 && n[0] == 0) begin
         wsum = 8 * n[7] + 4 * n[6]; den = n[7] + n[6];
      end else if (n[0] > 0 && n[7] == 0) begin
         wsum = -8 * n[0] - 4 * n[1]; den = n[0] + n[1];
      end else if (n[6] > 0 && n[1] == 0) begin
         wsum = 4 * n[6] + 2 * n[5]; den = n[6] + n[5];
      end else if (n[1] > 0 && n[6] == 0) begin
         wsum = -4 * n[1] - 2 * n[2]; den = n[1] + n[2];
      end else if (n[5] > 0) begin
         wsum = 2 * n[5] + n[4]; den = n[5] + n[4];
      end else if (n[2] > 0) begin
         wsum = -2 * n[2] - n[3]; den = n[2] + n[3];
      end else begin
         wsum = n[4] - n[3]; den = n[3] + n[4];
      end
      if (den > 0) pos_h = round_div(wsum * 100, den);
   endfunction

   function automatic void set_duties();
      longint lim, floor_duty, t;
      lim = err_cap * 100;
      floor_duty = (duty_min > duty_max) ? duty_max : duty_min;
      if (err_h > lim) begin
         right_h = 0; left_h = cap_duty(duty_max);
      end else if (err_h < -lim) begin
         right_h = cap_duty(duty_max); left_h = 0;
      end else if (err_h != 0 && err_h != lim && err_h != -lim) begin
         t = duty_max - ctl_h;
         if (t < duty_min) t = floor_duty;
         if (err_h > 0) begin
            right_h = cap_duty(t); left_h = cap_duty(duty_max);
         end else begin
            left_h = cap_duty(t); right_h = cap_duty(duty_max);
         end
      end else begin
         right_h = cap_duty((right_h + left_h) / 2 + 5000);
         left_h = right_h;
      end
   endfunction

   function automatic steer_out_type predict_steering(item_type it);
      longint n[8];
      longint il, c;
      logic any;
      steer_out_type r;
      any = 1'b0;
      if (it.mode) begin
         if (it.en) begin
            il = int_cap * 100;
            err_h = target + pos_h;
            if (int_sum < il && int_sum > -il) int_sum += err_h;
            else if (int_sum > il) int_sum = il;
            else if (int_sum < -il) int_sum = -il;
            der_h = err_h - err_prev;
            err_prev = err_h;
         end
         c = round_div(gain_p * err_h, 100) + round_div(gain_i * int_sum, 100)
           + round_div(gain_d * der_h, 100);
         if (c < 0) c = -c;
         if (c > 16777215) c = 16777215;
         ctl_h = c;
      end else if (it.en) begin
         for (int k = 0; k < 8; k++) begin
            n[k] = normalize(it.s[k]);
            if (n[k] != 0) any = 1'b1;
         end
         seen_h = any;
         if (any) begin
            locate_line(n);
            set_duties();
         end
      end
      if (!it.en) begin
         right_h = 0; left_h = 0;
      end
      r.right = right_h[15:0];
      r.left = left_h[15:0];
      r.pos = pos_h[10:0];
      r.err = err_h[11:0];
      r.ctl = ctl_h[23:0];
      r.seen = seen_h;
      return r;
   endfunction

   // drive one item, wait for it to be taken, then record what it must return
   task automatic send_item(item_type it, logic pin, steer_out_type want);
      steer_out_type exp_out;
      req_mode <= it.mode;
      req_enable <= it.en;
      sens <= it.s;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      exp_out = predict_steering(it);
      pending_q.push_back(pin ? want : exp_out);
      if ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, longint val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val[15:0];
      @(posedge clock);
      case (idx)
         CSR_KP: gain_p = val[15:0];
         CSR_KI: gain_i = val[15:0];
         CSR_KD: gain_d = val[15:0];
         CSR_SET_POINT: target = longint'($signed(val[10:0]));
         CSR_INT_LIMIT: int_cap = val[15:0];
         CSR_ERR_LIMIT: err_cap = val[4:0];
         CSR_MAX_DUTY: duty_max = val[15:0];
         CSR_MIN_DUTY: duty_min = val[15:0];
         default: ;
      endcase
   endtask

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      end
   endtask

   // result side: pop at random, check against the oldest expectation, watchdog
   always @(posedge clock) begin
      steer_out_type e;
      if (!reset) begin
         if (!rsp_empty && rsp_pop) begin
            if (pending_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, right %0d left %0d", $time,
                        rsp_right_duty, rsp_left_duty);
            end else begin
               e = pending_q.pop_front();
               check_field("right_duty", e.right, rsp_right_duty);
               check_field("left_duty", e.left, rsp_left_duty);
               check_field("line_position", $signed(e.pos), rsp_line_position);
               check_field("error_value", $signed(e.err), rsp_error_value);
               check_field("control_value", e.ctl, rsp_control_value);
               check_field("line_seen", e.seen, rsp_line_seen);
            end
         end
         if ((!rsp_empty && rsp_pop) || (req_push && !req_full)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("FAILURE");
            $finish;
         end
      end
      rsp_pop <= ($urandom_range(99) >= recv_idle);
   end

   row_type dir_tab[20] = '{
      '{'{1'b0, 1'b0, '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
          12'd4095, 12'd4095}}, 1'b1, '{16'd0, 16'd0, 11'd0, 12'd0, 24'd0, 1'b0}},
      '{'{1'b0, 1'b1, '{8{12'd0}}}, 1'b1, '{16'd0, 16'd0, 11'd0, 12'd0, 24'd0, 1'b0}},
      '{'{1'b1, 1'b1, '{8{12'd0}}}, 1'b1, '{16'd0, 16'd0, 11'd0, 12'd0, 24'd0, 1'b0}},
      '{'{1'b0, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 12'd4095}}, 1'b1,
        '{16'd5000, 16'd5000, 11'd800, 12'd0, 24'd0, 1'b1}},
      '{'{1'b1, 1'b1, '{8{12'd0}}}, 1'b1,
        '{16'd5000, 16'd5000, 11'd800, 12'd800, 24'd88008, 1'b1}},
      // error beyond the limit: hard turn
      '{'{1'b0, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 12'd4095}}, 1'b1,
        '{16'd0, 16'd49999, 11'd800, 12'd800, 24'd88008, 1'b1}},
      '{'{1'b0, 1'b1, '{12'd4095, 0, 0, 0, 0, 0, 0, 0}}, 1'b0, '0},
      '{'{1'b1, 1'b1, '{8{12'd0}}}, 1'b0, '0},
      '{'{1'b0, 1'b1, '{0, 0, 0, 0, 0, 12'd501, 12'd3500, 0}}, 1'b0, '0},
      '{'{1'b0, 1'b1, '{0, 12'd3499, 12'd2000, 0, 0, 0, 0, 0}}, 1'b0, '0},
      '{'{1'b0, 1'b1, '{0, 0, 0, 0, 12'd1000, 12'd1000, 0, 0}}, 1'b0, '0},
      '{'{1'b0, 1'b1, '{0, 0, 12'd700, 12'd900, 0, 0, 0, 0}}, 1'b0, '0},
      '{'{1'b0, 1'b1, '{0, 0, 0, 12'd500, 12'd3000, 0, 0, 0}}, 1'b0, '0},
      '{'{1'b1, 1'b1, '{8{12'd0}}}, 1'b0, '0},
      '{'{1'b0, 1'b1, '{0, 0, 0, 12'd501, 12'd501, 0, 0, 0}}, 1'b0, '0},
      '{'{1'b1, 1'b0, '{8{12'hfff}}}, 1'b0, '0},
      // outer pairs both lit, inner ones dark: falls through to a zero divisor
      '{'{1'b0, 1'b1, '{12'd4095, 12'd4095, 0, 0, 0, 0, 12'd4095, 12'd4095}}, 1'b0, '0},
      '{'{1'b1, 1'b1, '{8{12'd0}}}, 1'b0, '0},
      '{'{1'b1, 1'b1, '{8{12'd0}}}, 1'b0, '0},
      '{'{1'b0, 1'b1, '{0, 12'd2048, 12'd1, 0, 0, 0, 0, 0}}, 1'b0, '0}
   };

   initial begin
      item_type it;
      int c;
      gain_p = 10000; gain_i = 1; gain_d = 1000; target = 0;
      int_cap = 1000; err_cap = 6; duty_max = 49999; duty_min = 10000;
      pos_h = 0; err_h = 0; err_prev = 0; int_sum = 0;
      der_h = 0; ctl_h = 0; right_h = 0; left_h = 0; seen_h = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].pin, dir_tab[i].want);

      for (int ph = 0; ph < 5; ph++) begin
         drain();
         case (ph)
            0: begin
               write_csr(CSR_KP, 10000); write_csr(CSR_KI, 1); write_csr(CSR_KD, 1000);
               write_csr(CSR_SET_POINT, 0); write_csr(CSR_INT_LIMIT, 1000);
               write_csr(CSR_ERR_LIMIT, 6); write_csr(CSR_MAX_DUTY, 49999);
               write_csr(CSR_MIN_DUTY, 10000);
            end
            1: begin
               write_csr(CSR_KP, 65535); write_csr(CSR_KI, 65535); write_csr(CSR_KD, 65535);
               write_csr(CSR_SET_POINT, 800); write_csr(CSR_INT_LIMIT, 65535);
               write_csr(CSR_ERR_LIMIT, 16); write_csr(CSR_MAX_DUTY, 65535);
               write_csr(CSR_MIN_DUTY, 65535);
            end
            2: begin
               write_csr(CSR_KP, 0); write_csr(CSR_KI, 0); write_csr(CSR_KD, 0);
               write_csr(CSR_SET_POINT, -800); write_csr(CSR_INT_LIMIT, 0);
               write_csr(CSR_ERR_LIMIT, 0); write_csr(CSR_MAX_DUTY, 0);
               write_csr(CSR_MIN_DUTY, 0);
            end
            3: begin
               // trimmed-side floor above the duty ceiling, tight integral clamp
               write_csr(CSR_KP, $urandom_range(65535)); write_csr(CSR_KI, $urandom_range(65535));
               write_csr(CSR_KD, $urandom_range(65535));
               write_csr(CSR_SET_POINT, longint'($urandom_range(1600)) - 800);
               write_csr(CSR_INT_LIMIT, $urandom_range(20));
               write_csr(CSR_ERR_LIMIT, $urandom_range(16));
               write_csr(CSR_MAX_DUTY, 30000); write_csr(CSR_MIN_DUTY, 40000);
            end
            default: begin
               write_csr(CSR_KP, $urandom_range(65535)); write_csr(CSR_KI, $urandom_range(65535));
               write_csr(CSR_KD, $urandom_range(65535));
               write_csr(CSR_SET_POINT, longint'($urandom_range(1600)) - 800);
               write_csr(CSR_INT_LIMIT, $urandom_range(65535));
               write_csr(CSR_ERR_LIMIT, $urandom_range(16));
               write_csr(CSR_MAX_DUTY, $urandom_range(65535));
               write_csr(CSR_MIN_DUTY, $urandom_range(65535));
            end
         endcase
         csr_write <= 1'b0;
         case (ph % 3)
            0: begin send_idle = 11; recv_idle = 72; end
            1: begin send_idle = 72; recv_idle = 11; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase

         for (int n = 0; n < 160; n++) begin
            it.mode = ($urandom_range(99) < 35);
            it.en = ($urandom_range(99) < 90);
            if ($urandom_range(99) < 75) begin
               // a line under two neighboring sensors, faint noise elsewhere
               c = $urandom_range(6);
               for (int k = 0; k < 8; k++) it.s[k] = $urandom_range(520);
               it.s[c] = $urandom_range(501, 4095);
               it.s[c + 1] = $urandom_range(501, 4095);
            end else begin
               for (int k = 0; k < 8; k++) it.s[k] = $urandom_range(4095);
            end
            send_item(it, 1'b0, '0);
         end
      end

      req_push <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

>>> sim.f
design/lfsc_pkg.sv
design/lfsc_front.sv
design/lfsc_queue.sv
design/lfsc_back.sv
design/line_follower_steering_controller_unit.sv
tb/tb_line_follower_steering_controller_unit.sv
